>>> hw/rtl/bmm_pkg.sv
// Package for the bipartite matching block: sizes, queue entry type,
// controller states and configuration register codes.
// No dependencies.
package bmm_pkg;

  localparam int MAX_LEFT  = 32;
  localparam int MAX_RIGHT = 32;
  localparam int LW        = $clog2(MAX_LEFT);
  localparam int RW        = $clog2(MAX_RIGHT);
  localparam int CW        = 6;
  localparam int QDEPTH    = MAX_LEFT + MAX_LEFT;
  localparam int QAW       = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic CFG_LEFT_COUNT  = 1'b0;
  localparam logic CFG_RIGHT_COUNT = 1'b1;

  // search queue entry: a left vertex, or the group of right vertices it found
  typedef struct packed {
    logic                 is_grp;
    logic [LW-1:0]        lid;
    logic [MAX_RIGHT-1:0] mask;
  } qent_t;

  // inputs of the right-vertex lanes for one left vertex
  typedef struct packed {
    logic [MAX_RIGHT-1:0] row;
    logic [MAX_RIGHT-1:0] in_use;
    logic [MAX_RIGHT-1:0] visited;
    logic                 has_partner;
    logic [RW-1:0]        partner;
  } lane_in_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC,
    ST_POP,
    ST_EXEC,
    ST_GRP,
    ST_AUG,
    ST_EMIT
  } state_t;

endpackage

>>> hw/rtl/bmm_intf.sv
// Request and result channel interfaces of the matching block.
// Depends on bmm_pkg for field widths.
interface bmm_in_if import bmm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LW-1:0]        row_index;
  logic [MAX_RIGHT-1:0] row_edges;
  logic                 last_row;
  modport source (output valid, row_index, row_edges, last_row, input ready);
  modport sink (input valid, row_index, row_edges, last_row, output ready);
endinterface

interface bmm_out_if import bmm_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [LW-1:0] left_vertex;
  logic          is_matched;
  logic [RW-1:0] partner;
  logic          final_result;
  modport source (output valid, left_vertex, is_matched, partner, final_result,
                  input ready);
  modport sink (input valid, left_vertex, is_matched, partner, final_result,
                output ready);
endinterface

>>> hw/rtl/bmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/bmm_lanes.sv
// One lane per right vertex: decides which right vertices a left vertex
// newly discovers. Depends on bmm_pkg.
module bmm_lanes import bmm_pkg::*; (
  input  lane_in_t             lin,
  output logic [MAX_RIGHT-1:0] found
);
  for (genvar v = 0; v < MAX_RIGHT; v++) begin : g_lane
    // edge present, column in use, not yet seen, not the current partner
    assign found[v] = lin.row[v] & lin.in_use[v] & ~lin.visited[v] &
                      ~(lin.has_partner && (lin.partner == RW'(v)));
  end
endmodule

>>> hw/rtl/bmm_pick.sv
// Merge stage: lowest set bit of a lane mask, for ascending scan order.
// Depends on bmm_pkg.
module bmm_pick import bmm_pkg::*; (
  input  logic [MAX_RIGHT-1:0] mask,
  output logic                 any,
  output logic [RW-1:0]        idx
);
  always_comb begin
    idx = '0;
    for (int i = MAX_RIGHT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = RW'(i);
      end
    end
    any = |mask;
  end
endmodule

>>> hw/rtl/bipartite_max_matching.sv
// Maximum bipartite matching by repeated breadth-first augmenting searches.
// Rows load one per cycle; the row marked last starts a solve that holds
// in_req.ready low. A search queues free left vertices, expands each entry,
// takes a group's right vertices one at a time and closes it; an empty queue
// ends the solve; paths augment backwards. Then 1 result/cycle while ready.
// rst_n (synchronous) clears the matching, control and counts (both 32).
module bipartite_max_matching import bmm_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  bmm_in_if.sink         in_req,
  bmm_out_if.source      out_rsp,
  input  logic           cfg_we,
  input  logic           cfg_idx,
  input  logic [CW-1:0]  cfg_wdata
);
  state_t state_r, state_nxt;

  logic [CW-1:0]        n_cfg_r, m_cfg_r, n_r, n_clamp, m_clamp, cnt_r;
  logic [MAX_RIGHT-1:0] m_mask_r, m_mask_nxt;
  logic [MAX_RIGHT-1:0] edge_r [MAX_LEFT];
  logic [MAX_LEFT-1:0]  lm_vld_r, vis_l_r, lsrc_r;
  logic [RW-1:0]        lm_idx_r [MAX_LEFT];
  logic [RW-1:0]        lpar_r [MAX_LEFT];
  logic [MAX_RIGHT-1:0] rm_vld_r, vis_r_r, grp_r;
  logic [LW-1:0]        rm_idx_r [MAX_RIGHT];
  logic [LW-1:0]        rpar_r [MAX_RIGHT];
  logic [QAW:0]         head_r, tail_r;
  logic [RW-1:0]        cur_r;
  logic                 out_valid_r, out_matched_r, out_final_r;
  logic [LW-1:0]        out_lv_r;
  logic [RW-1:0]        out_partner_r;

  logic                 q_we;
  qent_t                q_wdata, q_rdata;
  lane_in_t             lin;
  logic [MAX_RIGHT-1:0] found;
  logic                 grp_any;
  logic [RW-1:0]        grp_v;
  logic [LW-1:0]        grp_p, aug_l, src_u;
  logic                 in_acc, emit_go;

  assign in_acc  = in_req.valid && in_req.ready;
  assign emit_go = !out_valid_r || out_rsp.ready;
  assign src_u   = cnt_r[LW-1:0];
  assign grp_p   = rm_idx_r[grp_v];
  assign aug_l   = rpar_r[cur_r];

  // clamp counts into 1..MAX
  assign n_clamp = (n_cfg_r == '0) ? CW'(1) :
                   (n_cfg_r > CW'(MAX_LEFT)) ? CW'(MAX_LEFT) : n_cfg_r;
  assign m_clamp = (m_cfg_r == '0) ? CW'(1) :
                   (m_cfg_r > CW'(MAX_RIGHT)) ? CW'(MAX_RIGHT) : m_cfg_r;
  assign m_mask_nxt = MAX_RIGHT'(((MAX_RIGHT + 1)'(1) << m_clamp) - (MAX_RIGHT + 1)'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cfg_r <= CW'(MAX_LEFT);
      m_cfg_r <= CW'(MAX_RIGHT);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LEFT_COUNT:  n_cfg_r <= cfg_wdata;
        CFG_RIGHT_COUNT: m_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lanes and merge
  assign lin.row         = edge_r[q_rdata.lid];
  assign lin.in_use      = m_mask_r;
  assign lin.visited     = vis_r_r;
  assign lin.has_partner = lm_vld_r[q_rdata.lid];
  assign lin.partner     = lm_idx_r[q_rdata.lid];

  bmm_lanes u_lanes (.lin(lin), .found(found));
  bmm_pick  u_pick  (.mask(grp_r), .any(grp_any), .idx(grp_v));

  // queue writes
  always_comb begin
    q_we    = 1'b0;
    q_wdata = '0;
    unique case (state_r)
      ST_SRC: begin
        q_we        = (cnt_r < n_r) && !lm_vld_r[src_u];
        q_wdata.lid = src_u;
      end
      ST_EXEC: begin
        q_we         = !q_rdata.is_grp && (found != '0);
        q_wdata.is_grp = 1'b1;
        q_wdata.lid  = q_rdata.lid;
        q_wdata.mask = found;
      end
      ST_GRP: begin
        q_we        = grp_any && rm_vld_r[grp_v] && !vis_l_r[grp_p];
        q_wdata.lid = grp_p;
      end
      default: ;
    endcase
  end

  bmm_ram #(.WIDTH($bits(qent_t)), .DEPTH(QDEPTH)) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(tail_r[QAW-1:0]),
    .wdata(q_wdata),
    .raddr(head_r[QAW-1:0]),
    .rdata(q_rdata)
  );

  // controller state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_req.last_row) state_nxt = ST_SRC;
      ST_SRC:  if (cnt_r == n_r) state_nxt = ST_POP;
      ST_POP:  state_nxt = (head_r == tail_r) ? ST_EMIT : ST_EXEC;
      ST_EXEC: state_nxt = q_rdata.is_grp ? ST_GRP : ST_POP;
      ST_GRP: begin
        if (!grp_any) state_nxt = ST_POP;
        else if (!rm_vld_r[grp_v]) state_nxt = ST_AUG;
      end
      ST_AUG:  if (lsrc_r[aug_l]) state_nxt = ST_SRC;
      ST_EMIT: if (emit_go && (cnt_r + CW'(1) == n_r)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control counters and match valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lm_vld_r    <= '0;
      rm_vld_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_we) tail_r <= tail_r + (QAW + 1)'(1);
      // result register: load on emit, else clear once taken
      if ((state_r == ST_EMIT) && emit_go) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_req.last_row) begin
            lm_vld_r <= '0;
            rm_vld_r <= '0;
            head_r   <= '0;
            tail_r   <= '0;
            cnt_r    <= '0;
          end
        end
        ST_SRC: begin
          if (cnt_r == n_r) cnt_r <= '0;
          else cnt_r <= cnt_r + CW'(1);
        end
        ST_POP: if (head_r != tail_r) head_r <= head_r + (QAW + 1)'(1);
        ST_AUG: begin
          lm_vld_r[aug_l] <= 1'b1;
          rm_vld_r[cur_r] <= 1'b1;
          if (lsrc_r[aug_l]) begin
            head_r <= '0;
            tail_r <= '0;
            cnt_r  <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            cnt_r <= (cnt_r + CW'(1) == n_r) ? '0 : cnt_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // search and matching payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) edge_r[in_req.row_index] <= in_req.row_edges;
        if (in_acc && in_req.last_row) begin
          n_r      <= n_clamp;
          m_mask_r <= m_mask_nxt;
          vis_l_r  <= '0;
          vis_r_r  <= '0;
        end
      end
      ST_SRC: begin
        if ((cnt_r < n_r) && !lm_vld_r[src_u]) begin
          vis_l_r[src_u] <= 1'b1;
          lsrc_r[src_u]  <= 1'b1;
        end
      end
      ST_EXEC: begin
        if (q_rdata.is_grp) begin
          grp_r <= q_rdata.mask;
        end else begin
          vis_r_r <= vis_r_r | found;
          for (int v = 0; v < MAX_RIGHT; v++) begin
            if (found[v]) rpar_r[v] <= q_rdata.lid;
          end
        end
      end
      ST_GRP: begin
        if (grp_any) begin
          grp_r[grp_v] <= 1'b0;
          cur_r        <= grp_v;
          if (rm_vld_r[grp_v] && !vis_l_r[grp_p]) begin
            vis_l_r[grp_p] <= 1'b1;
            lsrc_r[grp_p]  <= 1'b0;
            lpar_r[grp_p]  <= grp_v;
          end
        end
      end
      ST_AUG: begin
        lm_idx_r[aug_l] <= cur_r;
        rm_idx_r[cur_r] <= aug_l;
        cur_r           <= lpar_r[aug_l];
        if (lsrc_r[aug_l]) begin
          vis_l_r <= '0;
          vis_r_r <= '0;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_lv_r      <= src_u;
          out_matched_r <= lm_vld_r[src_u];
          out_partner_r <= lm_vld_r[src_u] ? lm_idx_r[src_u] : '0;
          out_final_r   <= (cnt_r + CW'(1) == n_r);
        end
      end
      default: ;
    endcase
  end

  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.left_vertex  = out_lv_r;
  assign out_rsp.is_matched   = out_matched_r;
  assign out_rsp.partner      = out_partner_r;
  assign out_rsp.final_result = out_final_r;

  // checks
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue head passed tail");
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= (QAW + 1)'(QDEPTH)) else $error("queue overflow");
  // pairs only balance between path walks
  a_match_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_AUG) |-> ($countones(lm_vld_r) == $countones(rm_vld_r)))
    else $error("matching unbalanced");
  a_lane_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && !q_rdata.is_grp) |-> ((found & vis_r_r) == '0))
    else $error("lane rediscovered a visited vertex");
endmodule
